// ===== hw/rtl/tdp_pkg.sv =====
// shared types and constants of the trial division primality tester
package tdp_pkg;

  // first odd candidate divisor and the stride between candidates
  localparam int CAND_FIRST = 3;
  localparam int CAND_STEP  = 2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;          // capture the incoming number
    logic init_cand;     // candidate divisor back to its first value
    logic next_cand;     // advance to the next odd candidate
    logic init_div;      // start a new remainder computation
    logic step;          // one restoring division step
    logic set_verdict;   // store verdict_value as the answer
    logic verdict_value; // answer to be stored
    logic load_out;      // move the answer into the output register
  } tdp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic lt2;       // number is zero or one
    logic is2;       // number is two
    logic even;      // lowest bit clear
    logic step_last; // final division step under way
    logic d_gt_q;    // candidate exceeds quotient, so candidate squared exceeds number
    logic rem_zero;  // candidate divides the number
  } tdp_status_t;

endpackage

// ===== hw/rtl/tdp_datapath.sv =====
// datapath: number, candidate divisor, bit-serial divider and result registers
module tdp_datapath import tdp_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic [W-1:0] number,
  input  tdp_cmd_t     cmd,
  output tdp_status_t  status,
  output logic         out_flag
);

  localparam int CNT_W = $clog2(W);
  localparam logic [W-1:0]     FIRST    = W'(CAND_FIRST);
  localparam logic [W-1:0]     STEP     = W'(CAND_STEP);
  localparam logic [W-1:0]     TWO      = W'(2);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

  logic [W-1:0]     value;
  logic [W-1:0]     cand;
  logic [W-1:0]     dvd;   // dividend shifts out at the top, quotient shifts in below
  logic [W:0]       rem;
  logic [CNT_W-1:0] cnt;
  logic             verdict;

  logic [W:0] shifted;
  logic       fits;

  // one restoring division step
  assign shifted = {rem[W-1:0], dvd[W-1]};
  assign fits    = shifted >= {1'b0, cand};

  // number register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value <= number;
    end
  end

  // candidate divisor
  always_ff @(posedge clk) begin
    if (cmd.init_cand) begin
      cand <= FIRST;
    end else if (cmd.next_cand) begin
      cand <= cand + STEP;
    end
  end

  // divider registers
  always_ff @(posedge clk) begin
    if (cmd.init_div) begin
      dvd <= value;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.step) begin
      dvd <= {dvd[W-2:0], fits};
      rem <= fits ? (shifted - {1'b0, cand}) : shifted;
      cnt <= cnt + 1'b1;
    end
  end

  // verdict and output flag, kept apart so a waiting result holds
  always_ff @(posedge clk) begin
    if (cmd.set_verdict) begin
      verdict <= cmd.verdict_value;
    end
    if (cmd.load_out) begin
      out_flag <= verdict;
    end
  end

  // status towards the controller
  always_comb begin
    status.lt2       = value < TWO;
    status.is2       = value == TWO;
    status.even      = ~value[0];
    status.step_last = cnt == CNT_LAST;
    status.d_gt_q    = cand > dvd;
    status.rem_zero  = rem == '0;
  end

endmodule

// ===== hw/rtl/tdp_ctrl.sv =====
// controller: sequences the special cases, the division loop and the output handshake
module tdp_ctrl import tdp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  tdp_status_t status,
  output tdp_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_ready = state == ST_IDLE;
  assign out_free = ~out_valid | out_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.lt2 || (status.even && !status.is2)) begin
          cmd.set_verdict   = 1'b1;
          cmd.verdict_value = 1'b0;
          state_next        = ST_DONE;
        end else if (status.is2) begin
          cmd.set_verdict   = 1'b1;
          cmd.verdict_value = 1'b1;
          state_next        = ST_DONE;
        end else begin
          cmd.init_cand = 1'b1;
          cmd.init_div  = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (status.step_last) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status.d_gt_q) begin
          cmd.set_verdict   = 1'b1;
          cmd.verdict_value = 1'b1;
          state_next        = ST_DONE;
        end else if (status.rem_zero) begin
          cmd.set_verdict   = 1'b1;
          cmd.verdict_value = 1'b0;
          state_next        = ST_DONE;
        end else begin
          cmd.next_cand = 1'b1;
          cmd.init_div  = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/trial_division_primality.sv =====
// top level of the trial division primality tester
//
//   channel  dir  handshake                      payload
//   s_axis   in   s_axis_tvalid/s_axis_tready    s_axis_tdata: number
//   m_axis   out  m_axis_tvalid/m_axis_tready    m_axis_tdata: prime_flag
//
// one transaction in, one out. zero, one, two and even numbers are settled without division.
// an odd number from three up is divided by the odd candidates in turn, each through a
// bit-serial divider giving one quotient bit a cycle (32 bits: up to about 2^15 candidates).
// one number is processed at a time; a new one is taken while the previous result still
// waits in the output register.
// synchronous reset clears the controller and the output valid flag.
module trial_division_primality import tdp_pkg::*; #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [NUMBER_WIDTH-1:0] number, zero fill up to a whole byte
  input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] prime_flag, [7:1] zero
  output logic [7:0]                          m_axis_tdata
);

  tdp_cmd_t    cmd;
  tdp_status_t status;
  logic        out_flag;

  // sequencing
  tdp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic and result storage
  tdp_datapath #(
    .W (NUMBER_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .number   (s_axis_tdata[NUMBER_WIDTH-1:0]),
    .cmd      (cmd),
    .status   (status),
    .out_flag (out_flag)
  );

  assign m_axis_tdata = {7'b0, out_flag};

endmodule

// ===== hw/rtl/tdp_checker.sv =====
// port-level checks of the primality tester and their binding
module tdp_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // only one number is worked on at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transaction");

  // a result is never shown in the cycle after a number is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared too early");

  // flag travels alone in the low bit
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:1] == 7'b0)
    else $error("padding bits set");

endmodule

bind trial_division_primality tdp_checker u_tdp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
